// File: design/nsp_pkg.sv
// Shared types, constants and the start-code test for the Annex B NAL splitter.
// Used by nsp_scan, nsp_fifo and h264_annexb_nal_splitter; depends on nothing.
package nsp_pkg;

    // Byte values and masks of the byte stream
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] TYPE_MASK = 8'h1F;

    // NAL unit types that carry parameter sets
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    // Window: up to four held bytes plus the new one
    localparam int WIN_BYTES = 5;
    localparam int HELD_BYTES = 4;
    localparam int MAX_RES = 5;
    localparam int CNT_W = 3;

    // Default depth of the result queue (power of two, at least MAX_RES)
    localparam int FIFO_DEPTH = 16;

    // Start-code test outcomes
    localparam logic [1:0] SC_NONE  = 2'd0;
    localparam logic [1:0] SC_THREE = 2'd1;
    localparam logic [1:0] SC_FOUR  = 2'd2;
    localparam logic [1:0] SC_UNDEC = 2'd3;

    typedef logic [WIN_BYTES-1:0][7:0] win_t;

    // One queued result byte
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       run_last;
    } res_t;

    // Test for a start code at offset p (0 or 1) of the first n window bytes
    function automatic logic [1:0] sc_at(input win_t w, input logic [CNT_W-1:0] n,
                                         input logic p, input logic fin);
        logic [CNT_W-1:0] i0;
        logic [CNT_W-1:0] i1;
        logic [CNT_W-1:0] i2;
        logic [CNT_W-1:0] i3;
        logic [1:0]       und;
        logic [1:0]       r;
        i0  = {{(CNT_W-1){1'b0}}, p};
        i1  = i0 + 3'd1;
        i2  = i0 + 3'd2;
        i3  = i0 + 3'd3;
        und = fin ? SC_NONE : SC_UNDEC;
        if (i0 >= n) begin
            r = und;
        end else if (w[i0] != BYTE_ZERO) begin
            r = SC_NONE;
        end else if (i1 >= n) begin
            r = und;
        end else if (w[i1] != BYTE_ZERO) begin
            r = SC_NONE;
        end else if (i2 >= n) begin
            r = und;
        end else if (w[i2] == BYTE_ONE) begin
            r = SC_THREE;
        end else if (w[i2] != BYTE_ZERO) begin
            r = SC_NONE;
        end else if (i3 >= n) begin
            r = und;
        end else begin
            r = (w[i3] == BYTE_ONE) ? SC_FOUR : SC_NONE;
        end
        return r;
    endfunction

endpackage

// File: design/nsp_scan.sv
// Byte window and start-code scan: holds undecided bytes, emits decided ones.
// Depends on nsp_pkg for the window type, result struct and sc_at.
module nsp_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [7:0]                    in_byte,
    input  logic                          in_final,
    output nsp_pkg::res_t                 res_out [nsp_pkg::MAX_RES],
    output logic [nsp_pkg::CNT_W-1:0]     res_cnt
);

    logic [nsp_pkg::HELD_BYTES-1:0][7:0] held_reg;
    logic [nsp_pkg::HELD_BYTES-1:0][7:0] held_next;
    logic [nsp_pkg::CNT_W-1:0]           held_cnt_reg;
    logic [nsp_pkg::CNT_W-1:0]           held_cnt_next;
    logic                                inside_reg;
    logic                                inside_next;
    logic                                await_reg;
    logic                                await_next;

    nsp_pkg::win_t             w;
    logic [nsp_pkg::CNT_W-1:0] n;
    logic [nsp_pkg::CNT_W-1:0] cnt;
    logic [1:0]                code;
    logic [1:0]                nx;
    logic                      done;
    logic                      in_unit;
    logic                      await_f;

    // Walk the window: each step drops a start code, a stray byte or emits a byte
    always_comb begin
        w       = {8'h00, held_reg};
        w[held_cnt_reg] = in_byte;
        n       = held_cnt_reg + 3'd1;
        cnt     = '0;
        done    = 1'b0;
        in_unit = inside_reg;
        await_f = await_reg;
        code    = nsp_pkg::SC_NONE;
        nx      = nsp_pkg::SC_NONE;
        for (int k = 0; k < nsp_pkg::MAX_RES; k++) begin
            res_out[k] = '0;
        end
        for (int it = 0; it < nsp_pkg::WIN_BYTES; it++) begin
            if (!done && n != '0) begin
                code = nsp_pkg::sc_at(w, n, 1'b0, in_final);
                if (code == nsp_pkg::SC_UNDEC) begin
                    done = 1'b1;
                end else if (code == nsp_pkg::SC_THREE) begin
                    in_unit = 1'b1;
                    await_f = 1'b1;
                    w = w >> 24;
                    n = n - 3'd3;
                end else if (code == nsp_pkg::SC_FOUR) begin
                    in_unit = 1'b1;
                    await_f = 1'b1;
                    w = w >> 32;
                    n = n - 3'd4;
                end else if (!in_unit) begin
                    w = w >> 8;
                    n = n - 3'd1;
                end else begin
                    nx = nsp_pkg::sc_at(w, n, 1'b1, in_final);
                    if (nx == nsp_pkg::SC_UNDEC) begin
                        done = 1'b1;
                    end else begin
                        res_out[cnt].data     = w[0];
                        res_out[cnt].first    = await_f;
                        res_out[cnt].last     = (nx != nsp_pkg::SC_NONE) ||
                                                (in_final && n == 3'd1);
                        res_out[cnt].run_last = 1'b0;
                        await_f = 1'b0;
                        cnt = cnt + 3'd1;
                        w = w >> 8;
                        n = n - 3'd1;
                    end
                end
            end
        end
        if (cnt != '0) begin
            res_out[cnt - 3'd1].run_last = 1'b1;
        end
        res_cnt = cnt;

        // Keep what is still undecided; end of buffer returns to reset state
        if (in_final) begin
            held_next     = '0;
            held_cnt_next = '0;
            inside_next   = 1'b0;
            await_next    = 1'b0;
        end else begin
            held_next     = w[nsp_pkg::HELD_BYTES-1:0];
            held_cnt_next = n;
            inside_next   = in_unit;
            await_next    = await_f;
        end
    end

    // Advance the window on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            held_cnt_reg <= '0;
            inside_reg   <= 1'b0;
            await_reg    <= 1'b0;
        end else if (step_en) begin
            held_reg     <= held_next;
            held_cnt_reg <= held_cnt_next;
            inside_reg   <= inside_next;
            await_reg    <= await_next;
        end
    end

endmodule

// File: design/nsp_fifo.sv
// Result queue: takes up to MAX_RES results per cycle, hands out one per cycle while pop is high.
// Depends on nsp_pkg for the result struct and width constants.
module nsp_fifo #(
    parameter int DEPTH = nsp_pkg::FIFO_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  nsp_pkg::res_t                push_data [nsp_pkg::MAX_RES],
    input  logic [nsp_pkg::CNT_W-1:0]    push_cnt,
    output logic                         room,
    output logic                         head_valid,
    output nsp_pkg::res_t                head_data,
    input  logic                         pop,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    nsp_pkg::res_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   level_next;
    logic            do_pop;

    assign do_pop     = pop && (level_reg != '0);
    assign room       = level_reg <= LW'(DEPTH - nsp_pkg::MAX_RES);
    assign head_valid = level_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign level_next = level_reg + LW'(push_cnt) - LW'(do_pop);

    // Write the pushed results at consecutive slots
    always_ff @(posedge aclk) begin
        for (int k = 0; k < nsp_pkg::MAX_RES; k++) begin
            if (nsp_pkg::CNT_W'(k) < push_cnt) begin
                mem_reg[wr_ptr_reg + AW'(k)] <= push_data[k];
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + AW'(do_pop);
            level_reg  <= level_next;
        end
    end

endmodule

// File: design/h264_annexb_nal_splitter.sv
// H.264 Annex B splitter top level: byte window scan feeding a result queue.
// Depends on nsp_pkg, nsp_scan and nsp_fifo.
//
// Usage:
//   The s_ channel takes one buffer byte per transfer; s_buffer_end marks the
//   last byte of a buffer. The m_ channel returns NAL unit payload bytes, one
//   per transfer, with unit_first/unit_type/parameter_set on the first byte of
//   a unit, unit_last on its final byte, and run_last on the last byte that a
//   given input transfer released. Start codes and bytes before the first
//   start code produce no output.
// Throughput and hold-back:
//   One input byte per cycle is accepted while s_ready is high. A decided byte
//   is written to the queue by the transfer that decides it; up to four bytes
//   are held back while a start code may still follow, and all are released
//   with the buffer's last byte. The five-byte window scan is combinational;
//   the result queue drains one byte per cycle while m_ready is high.
// Reset and stall:
//   Synchronous reset empties the window and the queue and starts a new buffer.
//   When m_ready is low results collect in the queue; s_ready drops while the
//   queue has fewer free slots than one input can release (five).
module h264_annexb_nal_splitter #(
    parameter int FIFO_DEPTH = nsp_pkg::FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       s_buffer_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_unit_first,
    output logic       m_unit_last,
    output logic [4:0] m_unit_type,
    output logic       m_parameter_set,
    output logic       m_run_last
);

    localparam int LW = $clog2(FIFO_DEPTH + 1);

    logic                       step_en;
    nsp_pkg::res_t              res [nsp_pkg::MAX_RES];
    logic [nsp_pkg::CNT_W-1:0]  res_cnt;
    logic [nsp_pkg::CNT_W-1:0]  push_cnt;
    nsp_pkg::res_t              head;
    logic                       room;
    logic [LW-1:0]              level;
    logic [7:0]                 type_byte;

    assign s_ready  = room;
    assign step_en  = s_valid && s_ready;
    assign push_cnt = step_en ? res_cnt : '0;

    nsp_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .in_byte  (s_stream_byte),
        .in_final (s_buffer_end),
        .res_out  (res),
        .res_cnt  (res_cnt)
    );

    nsp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (res),
        .push_cnt   (push_cnt),
        .room       (room),
        .head_valid (m_valid),
        .head_data  (head),
        .pop        (m_ready),
        .level      (level)
    );

    // Drive the result fields from the queue head
    assign type_byte       = head.data & nsp_pkg::TYPE_MASK;
    assign m_payload_byte  = head.data;
    assign m_unit_first    = head.first;
    assign m_unit_last     = head.last;
    assign m_run_last      = head.run_last;
    assign m_unit_type     = head.first ? type_byte[4:0] : 5'd0;
    assign m_parameter_set = head.first &&
                             (type_byte[4:0] == nsp_pkg::NAL_SPS ||
                              type_byte[4:0] == nsp_pkg::NAL_PPS);

    // Queue never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // An accepted byte always finds room for everything it can release
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |-> (level <= LW'(FIFO_DEPTH - nsp_pkg::MAX_RES)))
        else $error("byte accepted without queue room");

    // Parameter-set mark only on a unit's first byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_parameter_set) |-> m_unit_first)
        else $error("parameter_set outside first byte");

    // Nothing is offered right after reset
    assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("output valid after reset");

endmodule

// File: bench/h264_annexb_nal_splitter_test.sv
// Self-checking testbench for h264_annexb_nal_splitter: start-code search and NAL payload output.
// Streams directed and random Annex B buffers, predicts every payload byte, checks each transfer.
// Depends on nsp_pkg and the splitter RTL.
`timescale 1ns / 100ps

module h264_annexb_nal_splitter_test;

    localparam int TARGET_ITEMS = 450;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_TAIL    = 80;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT        = 200000;

    typedef enum logic [1:0] {START_NONE, START_WAIT, START_THREE, START_FOUR} start_kind_t;

    typedef logic [nsp_pkg::WIN_BYTES-1:0][7:0] window_t;

    // One input byte as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       last_byte;
        logic       drain_first;
    } stream_item_t;

    // One expected payload byte
    typedef struct packed {
        logic [7:0] payload;
        logic       first;
        logic       last;
        logic [4:0] utype;
        logic       pset;
        logic       rlast;
    } nal_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_stream_byte = 8'h00;
    logic       s_buffer_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_payload_byte;
    logic       m_unit_first;
    logic       m_unit_last;
    logic [4:0] m_unit_type;
    logic       m_parameter_set;
    logic       m_run_last;

    stream_item_t stream_q[$];
    nal_byte_t    nal_bytes_q[$];

    // Predictor state
    logic [7:0] held [nsp_pkg::HELD_BYTES];
    int         held_n = 0;
    bit         in_unit = 1'b0;
    bit         await_first = 1'b0;

    // Bookkeeping
    int n_errors = 0;
    int n_sent = 0;
    int n_received = 0;
    int n_units = 0;
    int n_buffers = 0;
    int total_items = 1 << 30;
    int cycles = 0;
    bit offering = 1'b0;
    bit hold_off = 1'b0;

    h264_annexb_nal_splitter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_stream_byte  (s_stream_byte),
        .s_buffer_end   (s_buffer_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_unit_first   (m_unit_first),
        .m_unit_last    (m_unit_last),
        .m_unit_type    (m_unit_type),
        .m_parameter_set(m_parameter_set),
        .m_run_last     (m_run_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Classify the window at offset p: start code, none, or more bytes needed
    function automatic start_kind_t scan_start(input window_t w, input int n, input int p,
                                               input bit fin);
        start_kind_t pend;
        pend = fin ? START_NONE : START_WAIT;
        if (p >= n) return pend;
        if (w[p] != nsp_pkg::BYTE_ZERO) return START_NONE;
        if (p + 1 >= n) return pend;
        if (w[p + 1] != nsp_pkg::BYTE_ZERO) return START_NONE;
        if (p + 2 >= n) return pend;
        if (w[p + 2] == nsp_pkg::BYTE_ONE) return START_THREE;
        if (w[p + 2] != nsp_pkg::BYTE_ZERO) return START_NONE;
        if (p + 3 >= n) return pend;
        return (w[p + 3] == nsp_pkg::BYTE_ONE) ? START_FOUR : START_NONE;
    endfunction

    // Take one stream byte and queue the payload bytes it releases
    task automatic split_byte(input logic [7:0] b, input bit fin);
        window_t     w;
        int          n;
        int          adv;
        int          nres;
        int          i;
        bit          stop;
        start_kind_t k;
        start_kind_t nx;
        nal_byte_t   r;
        w = '0;
        n = held_n;
        for (i = 0; i < n; i++) w[i] = held[i];
        w[n] = b;
        n++;
        nres = 0;
        stop = 1'b0;
        while (n > 0 && !stop) begin
            k = scan_start(w, n, 0, fin);
            if (k == START_WAIT) begin
                stop = 1'b1;
            end else begin
                adv = 1;
                if (k == START_THREE || k == START_FOUR) begin
                    in_unit = 1'b1;
                    await_first = 1'b1;
                    adv = (k == START_THREE) ? 3 : 4;
                end else if (in_unit) begin
                    nx = scan_start(w, n, 1, fin);
                    if (nx == START_WAIT) begin
                        stop = 1'b1;
                    end else begin
                        r.payload = w[0];
                        r.first   = await_first;
                        r.last    = (nx != START_NONE) || (fin && n == 1);
                        r.utype   = await_first ? w[0][4:0] : 5'd0;
                        r.pset    = await_first && (r.utype == nsp_pkg::NAL_SPS ||
                                                    r.utype == nsp_pkg::NAL_PPS);
                        r.rlast   = 1'b0;
                        nal_bytes_q = {nal_bytes_q, r};
                        await_first = 1'b0;
                        nres++;
                    end
                end
                // Drop the decided bytes from the front of the window
                if (!stop) begin
                    if (adv > n) adv = n;
                    for (i = 0; i < n - adv; i++) w[i] = w[i + adv];
                    n -= adv;
                end
            end
        end
        // Mark the last byte released by this transfer
        if (nres > 0) begin
            nal_bytes_q[nal_bytes_q.size() - 1].rlast = 1'b1;
        end
        if (fin) begin
            for (i = 0; i < nsp_pkg::HELD_BYTES; i++) held[i] = 8'h00;
            held_n = 0;
            in_unit = 1'b0;
            await_first = 1'b0;
        end else begin
            if (n > nsp_pkg::HELD_BYTES) n = nsp_pkg::HELD_BYTES;
            for (i = 0; i < nsp_pkg::HELD_BYTES; i++) held[i] = (i < n) ? w[i] : 8'h00;
            held_n = n;
        end
    endtask

    task automatic add_byte(input logic [7:0] data, input bit last_byte, input bit drain);
        stream_item_t it;
        it.data = data;
        it.last_byte = last_byte;
        it.drain_first = drain;
        stream_q = {stream_q, it};
    endtask

    // Byte biased toward the values that build start codes
    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(0, 3))
            0: return nsp_pkg::BYTE_ZERO;
            1: return nsp_pkg::BYTE_ONE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed buffer: optional junk, a few units, maybe a partial start code at the end
    task automatic add_buffer(input bit drain);
        logic [7:0] buf_q[$];
        int         units;
        int         len;
        int         u;
        int         j;
        for (j = $urandom_range(0, 2); j > 0; j--) buf_q = {buf_q, 8'($urandom_range(0, 255))};
        units = $urandom_range(1, 4);
        for (u = 0; u < units; u++) begin
            if ($urandom_range(0, 2) == 0) buf_q = {buf_q, nsp_pkg::BYTE_ZERO};
            if ($urandom_range(0, 5) == 0) buf_q = {buf_q, nsp_pkg::BYTE_ZERO};
            buf_q = {buf_q, nsp_pkg::BYTE_ZERO};
            buf_q = {buf_q, nsp_pkg::BYTE_ZERO};
            buf_q = {buf_q, nsp_pkg::BYTE_ONE};
            len = $urandom_range(0, 6);
            for (j = 0; j < len; j++) begin
                if (j == 0 && $urandom_range(0, 2) == 0)
                    buf_q = {buf_q, {3'($urandom_range(0, 7)), 5'($urandom_range(7, 8))}};
                else
                    buf_q = {buf_q, rnd_byte()};
            end
        end
        for (j = $urandom_range(0, 3); j > 0; j--) buf_q = {buf_q, nsp_pkg::BYTE_ZERO};
        for (j = 0; j < buf_q.size(); j++)
            add_byte(buf_q[j], j == buf_q.size() - 1, drain && j == 0);
        n_buffers++;
    endtask

    // Loose bytes with random buffer ends
    task automatic add_noise();
        int j;
        for (j = $urandom_range(1, 8); j > 0; j--)
            add_byte(rnd_byte(), $urandom_range(0, 3) == 0, 1'b0);
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            n_errors++;
        end
    endtask

    // Driver: offer queued bytes, predict on each transfer, idle in bursts
    stream_item_t cur_item = '0;
    int           gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            offering = 1'b0;
            gap_left = 0;
            s_valid <= 1'b0;
            s_stream_byte <= 8'h00;
            s_buffer_end <= 1'b0;
        end else begin
            if (offering && s_ready) begin
                split_byte(cur_item.data, cur_item.last_byte);
                n_sent++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stream_q.size() > 0) begin
                    if (stream_q[0].drain_first && nal_bytes_q.size() > 0 && !hold_off) begin
                        // hold until every expected byte has come back, except during the hold-off
                    end else if (n_sent < total_items - CALM_TAIL
                                 && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(0, 9);
                    end else begin
                        cur_item = stream_q.pop_front();
                        offering = 1'b1;
                    end
                end
            end
            s_valid <= offering;
            s_stream_byte <= cur_item.data;
            s_buffer_end <= cur_item.last_byte;
        end
    end

    // Monitor: check each result transfer against the oldest expected byte
    nal_byte_t want;
    int        stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (nal_bytes_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got byte %h",
                             $time, m_payload_byte);
                    n_errors++;
                end else begin
                    want = nal_bytes_q.pop_front();
                    check_field("payload_byte", want.payload, m_payload_byte);
                    check_field("unit_first", 8'(want.first), 8'(m_unit_first));
                    check_field("unit_last", 8'(want.last), 8'(m_unit_last));
                    check_field("unit_type", 8'(want.utype), 8'(m_unit_type));
                    check_field("parameter_set", 8'(want.pset), 8'(m_parameter_set));
                    check_field("run_last", 8'(want.rlast), 8'(m_run_last));
                    n_received++;
                    if (want.first) n_units++;
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (n_sent < total_items - CALM_TAIL && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            m_ready <= (stall_left == 0) && !hold_off;
        end
    end

    // Long receiver hold-off so the result queue fills and the input stalls
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            hold_off <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_off <= 1'b0;
        end
    end

    // Timeout
    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("h264_annexb_nal_splitter_test: done, errors");
        $finish;
    end

    initial begin
        int nbuf;
        for (int i = 0; i < nsp_pkg::HELD_BYTES; i++) held[i] = 8'h00;

        // Junk before the first start code, SPS after a four-byte start code
        add_byte(8'hAB, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h67, 1'b0, 1'b0);
        // Four-byte start code, then an empty unit
        add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        // PPS, then a zero run ahead of a start code
        add_byte(8'hE8, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        // Partial start code at the buffer end stays payload
        add_byte(8'h9F, 1'b0, 1'b0); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        // Empty unit at the buffer end, then a lone byte with no start code
        add_byte(8'h00, 1'b0, 1'b1); add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        n_buffers += 3;

        // Random part: mostly well-formed buffers, some loose noise
        nbuf = 0;
        while (stream_q.size() < TARGET_ITEMS - 15) begin
            if ($urandom_range(0, 6) == 0) begin
                add_noise();
            end else begin
                add_buffer(nbuf % 8 == 0);
                nbuf++;
            end
        end
        add_buffer(1'b0);
        total_items = stream_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (stream_q.size() > 0 || offering) @(posedge aclk);
        while (nal_bytes_q.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d stream bytes in about %0d buffers, %0d payload bytes in %0d units checked",
                 n_sent, n_buffers, n_received, n_units);
        if (n_errors == 0 && nal_bytes_q.size() == 0) begin
            $display("h264_annexb_nal_splitter_test: done, clean");
        end else begin
            $display("%0d errors, %0d expected bytes left", n_errors, nal_bytes_q.size());
            $display("h264_annexb_nal_splitter_test: done, errors");
        end
        $finish;
    end

endmodule
